FILE: sv/edge_interval_capture_fifo_macros.svh
// Assertion macros used by the checker file of the edge interval capture FIFO.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef EDGE_INTERVAL_CAPTURE_FIFO_MACROS_SVH
`define EDGE_INTERVAL_CAPTURE_FIFO_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ECF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ecf_pkg.sv
// Shared types and codes for the edge interval capture FIFO.
// Used by the top level and the checker; depends on nothing else.
package ecf_pkg;

  localparam int DEFAULT_FIFO_DEPTH = 256;

  localparam int CfgIndexW = 2;

  // Command codes of an input word.
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Outcome codes of a result word.
  localparam logic [2:0] OUT_ARMED   = 3'd0;
  localparam logic [2:0] OUT_WAIT    = 3'd1;
  localparam logic [2:0] OUT_NOISE   = 3'd2;
  localparam logic [2:0] OUT_STORED  = 3'd3;
  localparam logic [2:0] OUT_MISSED  = 3'd4;
  localparam logic [2:0] OUT_POP     = 3'd5;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] REG_SYNC_MIN     = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_SYNC_MAX     = 2'd1;
  localparam logic [CfgIndexW-1:0] REG_NOISE_MAX    = 2'd2;
  localparam logic [CfgIndexW-1:0] REG_PACKET_LIMIT = 2'd3;

  typedef struct packed {
    logic        command;
    logic [31:0] edge_time_us;
  } ecf_item_t;

  typedef struct packed {
    logic [2:0]  edge_outcome;
    logic        entry_valid;
    logic [31:0] interval_us;
    logic [47:0] start_time_us;
    logic        level_before;
    logic [31:0] packet_count;
    logic [31:0] total_count;
    logic [31:0] noise_count;
    logic [31:0] missed_count;
    logic        limit_reached;
  } ecf_result_t;

endpackage

FILE: sv/edge_interval_capture_fifo.sv
// Edge interval capture FIFO: takes one input word per cycle, edge or pop, while the
// output is not stalled, and returns exactly one result word for each, in order. Each
// accepted word is registered in the second stage, then in the result register. The
// first stage classifies edges, updates the counters and slot pointers and issues the
// interval RAM access; the second stage takes the registered RAM read data and keeps the
// running start time and level, so consecutive pops need no stall. Sustained rate is one
// word per clock unless the output stalls, since each word needs at most one access to
// the interval RAM, with one write and one read port. The RAM needs no clearing pass.
// Configuration is accepted every cycle and must only be written while the block is idle.
module edge_interval_capture_fifo #(
  parameter int FIFO_DEPTH = ecf_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  ecf_pkg::ecf_item_t                  item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output ecf_pkg::ecf_result_t                result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ecf_pkg::CfgIndexW-1:0]       cfg_index,
  input  logic [31:0]                         cfg_data
);

  import ecf_pkg::*;

  localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PtrW-1:0] LastSlot = PtrW'(FIFO_DEPTH - 1);

  // Configuration.
  logic [23:0] sync_min;
  logic [23:0] sync_max;
  logic [23:0] noise_max;
  logic [31:0] packet_limit;

  // First stage state.
  logic            armed;
  logic [31:0]     ref_time;
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [31:0]     packets;
  logic [31:0]     accepted;
  logic [31:0]     noise_cnt;
  logic [31:0]     missed;

  logic            armed_next;
  logic [31:0]     ref_time_next;
  logic [PtrW-1:0] wr_ptr_next;
  logic [PtrW-1:0] rd_ptr_next;
  logic [31:0]     packets_next;
  logic [31:0]     accepted_next;
  logic [31:0]     noise_cnt_next;
  logic [31:0]     missed_next;

  // Second stage.
  logic            s1_valid;
  ecf_result_t     s1_res;
  logic            s1_pop;
  logic            s1_hit;
  ecf_result_t     s1_res_next;
  logic            s1_pop_next;
  logic            s1_hit_next;

  logic [47:0]     running;
  logic            level;
  logic [47:0]     running_next;
  logic            level_next;
  ecf_result_t     result_next;

  logic            item_fire;
  logic            out_free;
  logic [31:0]     diff;
  logic            below;
  logic            above;
  logic [PtrW-1:0] wr_inc;
  logic [PtrW-1:0] rd_inc;
  logic            mem_we;
  logic            mem_re;
  logic [31:0]     mem_rdata;

  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || result_ready;
  assign item_ready = !s1_valid || out_free;
  assign item_fire  = item_valid && item_ready;

  assign diff   = item.edge_time_us - ref_time;
  assign below  = (sync_min != 24'd0) && (diff < {8'd0, sync_min});
  assign above  = (sync_max != 24'd0) && (diff > {8'd0, sync_max});
  assign wr_inc = (wr_ptr == LastSlot) ? '0 : wr_ptr + 1'b1;
  assign rd_inc = (rd_ptr == LastSlot) ? '0 : rd_ptr + 1'b1;

  always_comb begin
    armed_next     = armed;
    ref_time_next  = ref_time;
    wr_ptr_next    = wr_ptr;
    rd_ptr_next    = rd_ptr;
    packets_next   = packets;
    accepted_next  = accepted;
    noise_cnt_next = noise_cnt;
    missed_next    = missed;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    s1_pop_next    = 1'b0;
    s1_hit_next    = 1'b0;
    s1_res_next    = '0;
    if (item_fire) begin
      if (item.command == CMD_POP) begin
        s1_pop_next              = 1'b1;
        s1_res_next.edge_outcome = OUT_POP;
        if (rd_ptr != wr_ptr) begin
          mem_re      = 1'b1;
          s1_hit_next = 1'b1;
          rd_ptr_next = rd_inc;
        end
      end else if (!armed) begin
        armed_next               = 1'b1;
        ref_time_next            = item.edge_time_us;
        s1_res_next.edge_outcome = OUT_ARMED;
      end else if (packets == 32'd0 && (below || above)) begin
        s1_res_next.edge_outcome = OUT_WAIT;
      end else if (diff <= {8'd0, noise_max}) begin
        if (noise_max != 24'd0) begin
          noise_cnt_next = noise_cnt + 32'd1;
        end
        s1_res_next.edge_outcome = OUT_NOISE;
      end else begin
        if (sync_min != 24'd0 && !below && !above) begin
          packets_next = packets + 32'd1;
        end
        // One slot always stays free, so equal pointers mean empty.
        if (wr_inc == rd_ptr) begin
          missed_next              = missed + 32'd1;
          s1_res_next.edge_outcome = OUT_MISSED;
        end else begin
          mem_we                   = 1'b1;
          wr_ptr_next              = wr_inc;
          s1_res_next.edge_outcome = OUT_STORED;
        end
        accepted_next = accepted + 32'd1;
        ref_time_next = item.edge_time_us;
      end
    end
    s1_res_next.packet_count  = packets_next;
    s1_res_next.total_count   = accepted_next;
    s1_res_next.noise_count   = noise_cnt_next;
    s1_res_next.missed_count  = missed_next;
    s1_res_next.limit_reached = (packet_limit != 32'd0) && (packets_next > packet_limit);
  end

  ecf_ram #(
    .WIDTH (32),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_ptr),
    .wdata (diff),
    .re    (mem_re),
    .raddr (rd_ptr),
    .rdata (mem_rdata)
  );

  // The read data stays put while the second stage is stalled, since only a
  // newly accepted pop starts another read.
  always_comb begin
    result_next  = s1_res;
    running_next = running;
    level_next   = level;
    if (s1_pop) begin
      result_next.start_time_us = running;
      result_next.level_before  = level;
      if (s1_hit) begin
        result_next.entry_valid = 1'b1;
        result_next.interval_us = mem_rdata;
        running_next            = running + {16'd0, mem_rdata};
        level_next              = ~level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_min     <= '0;
      sync_max     <= '0;
      noise_max    <= '0;
      packet_limit <= '0;
      armed        <= 1'b0;
      ref_time     <= '0;
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      packets      <= '0;
      accepted     <= '0;
      noise_cnt    <= '0;
      missed       <= '0;
      running      <= '0;
      level        <= 1'b0;
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SYNC_MIN:     sync_min     <= cfg_data[23:0];
          REG_SYNC_MAX:     sync_max     <= cfg_data[23:0];
          REG_NOISE_MAX:    noise_max    <= cfg_data[23:0];
          REG_PACKET_LIMIT: packet_limit <= cfg_data;
          default: ;
        endcase
      end
      armed     <= armed_next;
      ref_time  <= ref_time_next;
      wr_ptr    <= wr_ptr_next;
      rd_ptr    <= rd_ptr_next;
      packets   <= packets_next;
      accepted  <= accepted_next;
      noise_cnt <= noise_cnt_next;
      missed    <= missed_next;
      if (item_fire) begin
        s1_valid <= 1'b1;
      end else if (out_free) begin
        s1_valid <= 1'b0;
      end
      if (s1_valid && out_free) begin
        result_valid <= 1'b1;
        running      <= running_next;
        level        <= level_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      s1_res <= s1_res_next;
      s1_pop <= s1_pop_next;
      s1_hit <= s1_hit_next;
    end
    if (s1_valid && out_free) begin
      result <= result_next;
    end
  end

endmodule

FILE: sv/ecf_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; holds the stored intervals of the edge interval capture FIFO.
module ecf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/ecf_checker.sv
// Port-level assertions for the edge interval capture FIFO, bound to its top level.
// Depends on ecf_pkg and edge_interval_capture_fifo_macros.svh.
`include "edge_interval_capture_fifo_macros.svh"

module ecf_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 result_valid,
  input logic                 result_ready,
  input ecf_pkg::ecf_result_t result
);

  import ecf_pkg::*;

  `ECF_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "stalled result word changed")
  `ECF_ASSERT_SAME(a_edge_no_pop_fields, result_valid && result.edge_outcome != OUT_POP, !result.entry_valid && result.interval_us == 32'd0 && result.start_time_us == 48'd0 && !result.level_before, "edge word carries pop fields")
  `ECF_ASSERT_SAME(a_empty_pop_zero, result_valid && result.edge_outcome == OUT_POP && !result.entry_valid, result.interval_us == 32'd0, "empty pop returned an interval")
  `ECF_ASSERT_SAME(a_reset_quiet, $past(rst), !result_valid, "result word valid right after reset")

endmodule

bind edge_interval_capture_fifo ecf_checker u_ecf_checker (.*);
